>>> sv/binary_arithmetic_encoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary arithmetic encoder.
// Each macro expands to one labeled concurrent assertion that is disabled
// while reset is asserted and reports through $error.
// ----------------------------------------------------------------------------
`ifndef BINARY_ARITHMETIC_ENCODER_ASSERT_SVH
`define BINARY_ARITHMETIC_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BAE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BAE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bae_pkg.sv
// ----------------------------------------------------------------------------
// bae_pkg
// Shared constants, command codes and the controller/datapath structs of the
// binary arithmetic encoder.
// ----------------------------------------------------------------------------
package bae_pkg;

    // Default sizes of the coder.
    localparam int CODE_BITS_DEF   = 16;
    localparam int FREQ_BITS_DEF   = 14;
    localparam int PENDING_MAX_DEF = 255;

    // Fixed sizes of the byte packer and the pending counter.
    localparam int BYTE_BITS = 8;
    localparam int BIT_CNT_W = 3;
    localparam int PEND_W    = 8;

    // Datapath operations issued by the controller.
    typedef logic [3:0] t_op;
    localparam t_op DP_NOP       = 4'd0;
    localparam t_op DP_MUL_H     = 4'd1;
    localparam t_op DP_DIV       = 4'd2;
    localparam t_op DP_MUL_L     = 4'd3;
    localparam t_op DP_NARROW    = 4'd4;
    localparam t_op DP_RENORM    = 4'd5;
    localparam t_op DP_PEND      = 4'd6;
    localparam t_op DP_FIN_FIRST = 4'd7;
    localparam t_op DP_FIN_BIT   = 4'd8;
    localparam t_op DP_PAD       = 4'd9;
    localparam t_op DP_FLUSH     = 4'd10;
    localparam t_op DP_ERR       = 4'd11;

    // Renormalization decision for the current interval.
    typedef logic [1:0] t_rcase;
    localparam t_rcase RC_EMIT0 = 2'd0;
    localparam t_rcase RC_EMIT1 = 2'd1;
    localparam t_rcase RC_UNDER = 2'd2;
    localparam t_rcase RC_STOP  = 2'd3;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic in_take;
        t_op  op;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic   is_fin;
        logic   triple_bad;
        logic   narrow_bad;
        t_rcase rcase;
        logic   pend_zero;
        logic   idx_zero;
        logic   hold_valid;
        logic   out_free;
        logic   bits_full;
        logic   bits_zero;
    } t_stat;

endpackage

>>> sv/bae_in_if.sv
// ----------------------------------------------------------------------------
// bae_in_if
// Request channel into the encoder: one encode or finish item per request.
// ----------------------------------------------------------------------------
interface bae_in_if #(
    parameter int FREQ_BITS = bae_pkg::FREQ_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [FREQ_BITS-1:0] cum_low;
    logic [FREQ_BITS-1:0] cum_upper;
    logic [FREQ_BITS-1:0] total;

    modport source (output valid, kind, cum_low, cum_upper, total, input ready);
    modport sink   (input valid, kind, cum_low, cum_upper, total, output ready);
endinterface

>>> sv/bae_out_if.sv
// ----------------------------------------------------------------------------
// bae_out_if
// Result channel out of the encoder: one code byte or error flag per result.
// ----------------------------------------------------------------------------
interface bae_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_stream;
    logic       pending_overflow;
    logic       input_error;

    modport source (output valid, out_byte, last_of_run, end_of_stream,
                    pending_overflow, input_error, input ready);
    modport sink   (input valid, out_byte, last_of_run, end_of_stream,
                    pending_overflow, input_error, output ready);
endinterface

>>> sv/bae_ctrl.sv
// ----------------------------------------------------------------------------
// bae_ctrl
// Sequencer of the encoder: steps the shared multiply-divide unit, the
// renormalization loop, the pending-bit drain and the finish flush.
// ----------------------------------------------------------------------------
module bae_ctrl #(
    parameter int CODE_BITS = bae_pkg::CODE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bae_pkg::t_stat i_stat,
    output bae_pkg::t_cmd  o_cmd
);
    import bae_pkg::*;

    localparam int CW = $clog2(CODE_BITS + 2);
    localparam logic [CW-1:0] DIV_LAST  = CW'(CODE_BITS);
    localparam logic [CW-1:0] GUARD_END = CW'(CODE_BITS + 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CHECK     = 4'd1;
    localparam logic [3:0] S_MUL_H     = 4'd2;
    localparam logic [3:0] S_DIV_H     = 4'd3;
    localparam logic [3:0] S_MUL_L     = 4'd4;
    localparam logic [3:0] S_DIV_L     = 4'd5;
    localparam logic [3:0] S_NARROW    = 4'd6;
    localparam logic [3:0] S_RENORM    = 4'd7;
    localparam logic [3:0] S_PEND      = 4'd8;
    localparam logic [3:0] S_FIN_FIRST = 4'd9;
    localparam logic [3:0] S_FIN_BITS  = 4'd10;
    localparam logic [3:0] S_PAD       = 4'd11;
    localparam logic [3:0] S_FLUSH     = 4'd12;
    localparam logic [3:0] S_ERR       = 4'd13;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          can_shift;
    logic          stage_ok;

    // A shift that completes a byte must be able to move the held byte out.
    assign can_shift = !(i_stat.bits_full && i_stat.hold_valid && !i_stat.out_free);
    assign stage_ok  = !i_stat.hold_valid || i_stat.out_free;

    // Next state and command decode.
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_in_ready    = 1'b0;
        o_cmd.in_take = 1'b0;
        o_cmd.op      = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.in_take = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.is_fin) begin
                    n_state = S_FIN_FIRST;
                end else if (i_stat.triple_bad) begin
                    n_state = S_ERR;
                end else begin
                    n_state = S_MUL_H;
                end
            end
            S_MUL_H: begin
                o_cmd.op = DP_MUL_H;
                n_cnt    = '0;
                n_state  = S_DIV_H;
            end
            S_DIV_H: begin
                o_cmd.op = DP_DIV;
                n_cnt    = r_cnt + CW'(1);
                if (r_cnt == DIV_LAST) begin
                    n_state = S_MUL_L;
                end
            end
            S_MUL_L: begin
                o_cmd.op = DP_MUL_L;
                n_cnt    = '0;
                n_state  = S_DIV_L;
            end
            S_DIV_L: begin
                o_cmd.op = DP_DIV;
                n_cnt    = r_cnt + CW'(1);
                if (r_cnt == DIV_LAST) begin
                    n_state = S_NARROW;
                end
            end
            S_NARROW: begin
                if (i_stat.narrow_bad) begin
                    n_state = S_ERR;
                end else begin
                    o_cmd.op = DP_NARROW;
                    n_cnt    = '0;
                    n_state  = S_RENORM;
                end
            end
            S_RENORM: begin
                if (r_cnt == GUARD_END || i_stat.rcase == RC_STOP) begin
                    n_state = S_FLUSH;
                end else if (i_stat.rcase == RC_UNDER || can_shift) begin
                    o_cmd.op = DP_RENORM;
                    n_cnt    = r_cnt + CW'(1);
                    if (i_stat.rcase != RC_UNDER && !i_stat.pend_zero) begin
                        n_state = S_PEND;
                    end
                end
            end
            S_PEND: begin
                if (i_stat.pend_zero) begin
                    n_state = i_stat.is_fin ? S_FIN_BITS : S_RENORM;
                end else if (can_shift) begin
                    o_cmd.op = DP_PEND;
                end
            end
            S_FIN_FIRST: begin
                if (can_shift) begin
                    o_cmd.op = DP_FIN_FIRST;
                    n_state  = S_PEND;
                end
            end
            S_FIN_BITS: begin
                if (can_shift) begin
                    o_cmd.op = DP_FIN_BIT;
                    if (i_stat.idx_zero) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (i_stat.bits_zero) begin
                    n_state = S_FLUSH;
                end else if (stage_ok) begin
                    o_cmd.op = DP_PAD;
                    n_state  = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (stage_ok) begin
                    o_cmd.op = DP_FLUSH;
                    n_state  = S_IDLE;
                end
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.op = DP_ERR;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and loop counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

>>> sv/bae_datapath.sv
// ----------------------------------------------------------------------------
// bae_datapath
// Coding interval, shared multiply and restoring divider, pending counter,
// MSB-first byte packer, one-byte hold stage and the output register.
// ----------------------------------------------------------------------------
module bae_datapath #(
    parameter int CODE_BITS   = bae_pkg::CODE_BITS_DEF,
    parameter int FREQ_BITS   = bae_pkg::FREQ_BITS_DEF,
    parameter int PENDING_MAX = bae_pkg::PENDING_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bae_pkg::t_cmd        i_cmd,
    output bae_pkg::t_stat       o_stat,
    input  logic                 i_kind,
    input  logic [FREQ_BITS-1:0] i_cum_low,
    input  logic [FREQ_BITS-1:0] i_cum_upper,
    input  logic [FREQ_BITS-1:0] i_total,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_last_of_run,
    output logic                 o_out_end_of_stream,
    output logic                 o_out_pending_overflow,
    output logic                 o_out_input_error
);
    import bae_pkg::*;

    localparam int QW = CODE_BITS + 1;
    localparam int PW = QW + FREQ_BITS;
    localparam int IW = $clog2(CODE_BITS);
    localparam logic [CODE_BITS-1:0] HALF    = {1'b1, {(CODE_BITS-1){1'b0}}};
    localparam logic [CODE_BITS-1:0] QUARTER = {2'b01, {(CODE_BITS-2){1'b0}}};
    localparam logic [CODE_BITS-1:0] THREEQ  = {2'b11, {(CODE_BITS-2){1'b0}}};
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(BYTE_BITS - 1);
    localparam logic [PEND_W-1:0]    PEND_TOP = PEND_W'(PENDING_MAX);

    // Latched request.
    logic                 r_kind;
    logic [FREQ_BITS-1:0] r_cl, r_ch, r_tot;
    // Coder state.
    logic [CODE_BITS-1:0] r_low, n_low, r_high, n_high;
    logic [PEND_W-1:0]    r_pend, n_pend;
    logic [BYTE_BITS-1:0] r_shift, n_shift;
    logic [BIT_CNT_W-1:0] r_bits, n_bits;
    logic                 r_ovf, n_ovf;
    // Divider and sequencing payload.
    logic [FREQ_BITS-1:0] r_rem, n_rem;
    logic [QW-1:0]        r_quo, n_quo, r_qh, n_qh;
    logic                 r_pbit, n_pbit;
    logic [IW-1:0]        r_idx, n_idx;
    // Hold stage and output register.
    logic                 r_hold_valid, n_hold_valid;
    logic [BYTE_BITS-1:0] r_hold_byte, n_hold_byte;
    logic                 r_hold_ovf, n_hold_ovf;
    logic                 r_out_valid, n_out_valid;
    logic [BYTE_BITS-1:0] r_out_byte, n_out_byte;
    logic                 r_out_last, n_out_last;
    logic                 r_out_eos, n_out_eos;
    logic                 r_out_ovf, n_out_ovf;
    logic                 r_out_err, n_out_err;

    logic [QW-1:0]        w_width;
    logic [FREQ_BITS-1:0] w_mul_op;
    logic [PW-1:0]        w_prod;
    logic [FREQ_BITS:0]   w_trial, w_diff;
    logic                 w_ge;
    logic [QW-1:0]        w_nh, w_nh_m1, w_nl;
    logic [CODE_BITS-1:0] w_sub, w_lm, w_hm;
    t_rcase               w_rcase;
    logic                 w_fin_bit;
    logic [BIT_CNT_W-1:0] w_pad_sh;

    logic                 sh_en, sh_bit;
    logic [BYTE_BITS-1:0] sh_word;
    logic                 st_en;
    logic [BYTE_BITS-1:0] st_byte;
    logic                 push_en, push_last, push_eos, push_ovf, push_err;
    logic [BYTE_BITS-1:0] push_byte;

    // Interval width and the shared multiplier.
    assign w_width  = {1'b0, r_high} - {1'b0, r_low} + QW'(1);
    assign w_mul_op = (i_cmd.op == DP_MUL_H) ? r_ch : r_cl;
    assign w_prod   = PW'(w_width) * PW'(w_mul_op);

    // One restoring division step: one quotient bit a cycle.
    assign w_trial = {r_rem, r_quo[QW-1]};
    assign w_ge    = w_trial >= {1'b0, r_tot};
    assign w_diff  = w_trial - {1'b0, r_tot};

    // New interval bounds from the two quotients.
    assign w_nh    = {1'b0, r_low} + r_qh;
    assign w_nl    = {1'b0, r_low} + r_quo;
    assign w_nh_m1 = w_nh - QW'(1);

    // Renormalization decision.
    always_comb begin
        if (r_high < HALF) begin
            w_rcase = RC_EMIT0;
        end else if (r_low >= HALF) begin
            w_rcase = RC_EMIT1;
        end else if (r_low >= QUARTER && r_high < THREEQ) begin
            w_rcase = RC_UNDER;
        end else begin
            w_rcase = RC_STOP;
        end
    end

    assign w_sub = (w_rcase == RC_EMIT1) ? HALF :
                   (w_rcase == RC_UNDER) ? QUARTER : '0;
    assign w_lm  = r_low - w_sub;
    assign w_hm  = r_high - w_sub;

    assign w_fin_bit = r_low >= QUARTER;
    assign w_pad_sh  = BIT_CNT_W'(BYTE_BITS) - r_bits;

    // Status to the controller.
    always_comb begin
        o_stat.is_fin     = r_kind;
        o_stat.triple_bad = (r_tot == '0) || (r_ch > r_tot) || (r_cl >= r_ch);
        o_stat.narrow_bad = (w_nh == '0) || (w_nh_m1 < w_nl);
        o_stat.rcase      = w_rcase;
        o_stat.pend_zero  = r_pend == '0;
        o_stat.idx_zero   = r_idx == '0;
        o_stat.hold_valid = r_hold_valid;
        o_stat.out_free   = !r_out_valid || i_out_ready;
        o_stat.bits_full  = r_bits == BIT_LAST;
        o_stat.bits_zero  = r_bits == '0;
    end

    // Operation decode, byte packing, hold stage and result push.
    always_comb begin
        n_low        = r_low;
        n_high       = r_high;
        n_pend       = r_pend;
        n_shift      = r_shift;
        n_bits       = r_bits;
        n_ovf        = r_ovf;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_qh         = r_qh;
        n_pbit       = r_pbit;
        n_idx        = r_idx;
        n_hold_valid = r_hold_valid;
        n_hold_byte  = r_hold_byte;
        n_hold_ovf   = r_hold_ovf;
        sh_en        = 1'b0;
        sh_bit       = 1'b0;
        sh_word      = '0;
        st_en        = 1'b0;
        st_byte      = '0;
        push_en      = 1'b0;
        push_byte    = '0;
        push_last    = 1'b0;
        push_eos     = 1'b0;
        push_ovf     = 1'b0;
        push_err     = 1'b0;

        unique case (i_cmd.op)
            DP_MUL_H: begin
                n_rem = w_prod[PW-1:QW];
                n_quo = w_prod[QW-1:0];
            end
            DP_MUL_L: begin
                n_qh  = r_quo;
                n_rem = w_prod[PW-1:QW];
                n_quo = w_prod[QW-1:0];
            end
            DP_DIV: begin
                n_rem = w_ge ? w_diff[FREQ_BITS-1:0] : w_trial[FREQ_BITS-1:0];
                n_quo = {r_quo[QW-2:0], w_ge};
            end
            DP_NARROW: begin
                n_high = w_nh_m1[CODE_BITS-1:0];
                n_low  = w_nl[CODE_BITS-1:0];
            end
            DP_RENORM: begin
                if (w_rcase == RC_UNDER) begin
                    if (r_pend >= PEND_TOP) begin
                        n_pend = PEND_TOP;
                        n_ovf  = 1'b1;
                    end else begin
                        n_pend = r_pend + PEND_W'(1);
                    end
                end else begin
                    sh_en  = 1'b1;
                    sh_bit = (w_rcase == RC_EMIT1);
                    n_pbit = (w_rcase != RC_EMIT1);
                end
                n_low  = {w_lm[CODE_BITS-2:0], 1'b0};
                n_high = {w_hm[CODE_BITS-2:0], 1'b1};
            end
            DP_PEND: begin
                sh_en  = 1'b1;
                sh_bit = r_pbit;
                n_pend = r_pend - PEND_W'(1);
            end
            DP_FIN_FIRST: begin
                sh_en  = 1'b1;
                sh_bit = w_fin_bit;
                n_pbit = !w_fin_bit;
                n_idx  = IW'(CODE_BITS - 2);
            end
            DP_FIN_BIT: begin
                sh_en  = 1'b1;
                sh_bit = r_low[r_idx];
                n_idx  = r_idx - IW'(1);
            end
            DP_PAD: begin
                st_en   = 1'b1;
                st_byte = r_shift << w_pad_sh;
            end
            DP_FLUSH: begin
                push_en      = r_hold_valid;
                push_byte    = r_hold_byte;
                push_last    = 1'b1;
                push_eos     = r_kind;
                push_ovf     = r_hold_ovf;
                n_hold_valid = 1'b0;
                if (r_kind) begin
                    n_low   = '0;
                    n_high  = '1;
                    n_pend  = '0;
                    n_shift = '0;
                    n_bits  = '0;
                    n_ovf   = 1'b0;
                end
            end
            DP_ERR: begin
                push_en   = 1'b1;
                push_last = 1'b1;
                push_ovf  = r_ovf;
                push_err  = 1'b1;
            end
            default: begin
            end
        endcase

        // Shift one code bit in; a full byte goes to the hold stage.
        if (sh_en) begin
            sh_word = {r_shift[BYTE_BITS-2:0], sh_bit};
            if (r_bits == BIT_LAST) begin
                st_en   = 1'b1;
                st_byte = sh_word;
            end else begin
                n_shift = sh_word;
                n_bits  = r_bits + BIT_CNT_W'(1);
            end
        end

        // A new byte moves the held one out; it is not the last of its run.
        if (st_en) begin
            if (r_hold_valid) begin
                push_en   = 1'b1;
                push_byte = r_hold_byte;
                push_ovf  = r_hold_ovf;
            end
            n_hold_valid = 1'b1;
            n_hold_byte  = st_byte;
            n_hold_ovf   = r_ovf;
            n_shift      = '0;
            n_bits       = '0;
        end
    end

    // Output register.
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_eos   = r_out_eos;
        n_out_ovf   = r_out_ovf;
        n_out_err   = r_out_err;
        if (push_en) begin
            n_out_valid = 1'b1;
            n_out_byte  = push_byte;
            n_out_last  = push_last;
            n_out_eos   = push_eos;
            n_out_ovf   = push_ovf;
            n_out_err   = push_err;
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low        <= '0;
            r_high       <= '1;
            r_pend       <= '0;
            r_shift      <= '0;
            r_bits       <= '0;
            r_ovf        <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_low        <= n_low;
            r_high       <= n_high;
            r_pend       <= n_pend;
            r_shift      <= n_shift;
            r_bits       <= n_bits;
            r_ovf        <= n_ovf;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            r_kind <= i_kind;
            r_cl   <= i_cum_low;
            r_ch   <= i_cum_upper;
            r_tot  <= i_total;
        end
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_qh        <= n_qh;
        r_pbit      <= n_pbit;
        r_idx       <= n_idx;
        r_hold_byte <= n_hold_byte;
        r_hold_ovf  <= n_hold_ovf;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_eos   <= n_out_eos;
        r_out_ovf   <= n_out_ovf;
        r_out_err   <= n_out_err;
    end

    assign o_out_valid            = r_out_valid;
    assign o_out_byte             = r_out_byte;
    assign o_out_last_of_run      = r_out_last;
    assign o_out_end_of_stream    = r_out_eos;
    assign o_out_pending_overflow = r_out_ovf;
    assign o_out_input_error      = r_out_err;

endmodule

>>> sv/binary_arithmetic_encoder.sv
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder
//
// Integer arithmetic encoder with a 16-bit coding interval by default. Each
// encode request carries the cumulative counts below and up to the symbol and
// the total from an external model; the block narrows the interval and emits
// code bytes MSB first, one result per completed byte, with last_of_run on the
// final byte of each request. An encode request that completes no byte gives
// no result, and an invalid triple gives a single result flagged input_error
// with no state change. A finish request flushes the closing bits and a
// zero-padded partial byte, marks it end_of_stream, and returns the coder to
// its reset state. One request is worked on at a time. An encode request
// runs the shared multiplier and the restoring divider, which produces one
// quotient bit a cycle and runs once for each interval bound, and then the
// renormalization steps and the release of pending bits; a finish request
// shifts out the closing bits and the pending bits. A completed byte waits
// in a one-byte hold stage and then in an output register. The coder stalls
// when a byte completes, or a request closes with a byte held, while both
// are still occupied; an error result waits for a free output register.
// ----------------------------------------------------------------------------
module binary_arithmetic_encoder #(
    parameter int CODE_BITS   = bae_pkg::CODE_BITS_DEF,
    parameter int FREQ_BITS   = bae_pkg::FREQ_BITS_DEF,
    parameter int PENDING_MAX = bae_pkg::PENDING_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bae_in_if.sink     i_in,
    bae_out_if.source  o_out
);
    import bae_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_in.ready = w_in_ready;

    // Sequencer.
    bae_ctrl #(
        .CODE_BITS (CODE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Interval arithmetic, bit packing and result register.
    bae_datapath #(
        .CODE_BITS   (CODE_BITS),
        .FREQ_BITS   (FREQ_BITS),
        .PENDING_MAX (PENDING_MAX)
    ) u_datapath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (w_cmd),
        .o_stat                 (w_stat),
        .i_kind                 (i_in.kind),
        .i_cum_low              (i_in.cum_low),
        .i_cum_upper            (i_in.cum_upper),
        .i_total                (i_in.total),
        .i_out_ready            (o_out.ready),
        .o_out_valid            (o_out.valid),
        .o_out_byte             (o_out.out_byte),
        .o_out_last_of_run      (o_out.last_of_run),
        .o_out_end_of_stream    (o_out.end_of_stream),
        .o_out_pending_overflow (o_out.pending_overflow),
        .o_out_input_error      (o_out.input_error)
    );

    // Checks on the sequencing and the result flags.
`include "binary_arithmetic_encoder_assert.svh"

    `BAE_ASSERT_IMP(a_ready_hold_empty, i_clk, i_rst_n, i_in.ready, !w_stat.hold_valid, "request taken while a byte is still held")
    `BAE_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "ready stayed high after a request was taken")
    `BAE_ASSERT_IMP(a_error_is_last, i_clk, i_rst_n, o_out.valid && o_out.input_error, o_out.last_of_run && !o_out.end_of_stream && (o_out.out_byte == 8'd0), "error result is malformed")
    `BAE_ASSERT_IMP(a_eos_is_last, i_clk, i_rst_n, o_out.valid && o_out.end_of_stream, o_out.last_of_run, "end of stream without last of run")

endmodule
